FILE: hw/rtl/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg: shared types and constants
// Item structs, kind codes and register indexes for the packetizer.
// ----------------------------------------------------------------------------
package rlp_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  out_byte;
    logic [31:0] seq_number;
    logic        last_of_packet;
    logic        byte_dropped;
    logic        packet_formed;
    logic        packet_discarded;
    logic [7:0]  queued_packets;
  } out_item_t;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_POP  = 2'd2;

  localparam logic [1:0] CFG_REFILL   = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_QLIMIT   = 2'd2;

  localparam logic [23:0] TOKEN_ONE   = 24'h01_0000;
  localparam logic [23:0] RST_REFILL  = 24'd1966;
  localparam logic [7:0]  RST_CAP     = 8'd60;
  localparam logic [7:0]  RST_QLIMIT  = 8'd120;

  // result queue between bookkeeping and output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

endpackage

FILE: hw/rtl/rlp_front.sv
// ----------------------------------------------------------------------------
// rlp_front: bookkeeping front end
// Bucket, stage and queue state; chunk pool memory; one item per cycle.
// ----------------------------------------------------------------------------
module rlp_front import rlp_pkg::*; #(
  parameter int PAYLOAD_BYTES = 256,
  parameter int QUEUE_PACKETS = 128,
  parameter int STAGE_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  in_item_t    item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [23:0] cfg_wdata,
  output logic        res_valid,
  output out_item_t   res
);

  localparam int P    = PAYLOAD_BYTES;
  localparam int Q    = QUEUE_PACKETS;
  localparam int S    = STAGE_BYTES;
  localparam int NS   = (S + P - 1) / P;
  localparam int POOL = NS + Q;
  localparam int NSW  = (NS > 1) ? $clog2(NS) : 1;
  localparam int QW   = (Q > 1) ? $clog2(Q) : 1;
  localparam int QCW  = $clog2(Q + 1);
  localparam int PW   = (P > 1) ? $clog2(P) : 1;
  localparam int CW   = $clog2(POOL);
  localparam int AW   = $clog2(POOL * P);
  localparam int SCW  = $clog2(S + 1);
  localparam int LW   = (QCW > 8) ? QCW : 8;

  logic [23:0]    refill_r, lvl_r, lvl_nxt;
  logic [7:0]     cap_cfg_r, qlim_cfg_r;
  logic [31:0]    seq_r;
  logic [SCW-1:0] scnt_r, scnt_a, scnt_nxt;
  logic [NSW-1:0] sf_r, wpos_r;
  logic [PW-1:0]  fill_r, roff_r;
  logic [QW-1:0]  qh_r, qt_r, qh_inc, qt_inc;
  logic [QCW-1:0] qc_r, qc_nxt;

  // chunk maps: stage position -> chunk, queue slot -> chunk
  logic [CW-1:0]  stg_tab_r  [NS];
  logic [NS-1:0]  stg_v_r;
  logic [CW-1:0]  slot_mem [Q];

  // chunks of the tail and head slots, kept ready in registers;
  // a slot not yet written owns chunk NS + slot
  logic [CW-1:0]  tail_rd_r, tail_dflt_r, head_rd_r, head_wr_r;
  logic           tail_sel_r, head_sel_r;

  logic [7:0]     mem [POOL * P];
  logic [31:0]    seqm [Q];

  logic is_b, is_t, is_p, stg_wr, full, cut, qput, disc, pop_hit, pop_last;
  logic [24:0] sum;
  logic [23:0] cap, lvl_a, lvl_b;
  logic [LW-1:0] lim;
  logic [CW-1:0] c_front, c_wr, c_tail, c_head;
  logic [AW-1:0] wr_addr, rd_addr;

  logic        s1v_r, acc_r, hit_r, last_r, drop_r, form_r, disc_r;
  logic [7:0]  qp_r, rd_byte_r;
  logic [31:0] rd_seq_r;

  assign is_b = take && (item.func == FUNC_BYTE);
  assign is_t = take && (item.func == FUNC_TICK);
  assign is_p = take && (item.func == FUNC_POP);

  assign stg_wr = is_b && (scnt_r < SCW'(S));
  assign scnt_a = scnt_r + SCW'(stg_wr);
  assign full   = (is_b || is_t) && (32'(scnt_a) >= 32'(P));

  assign cap   = {cap_cfg_r, 16'h0000};
  assign sum   = {1'b0, lvl_r} + {1'b0, refill_r};
  assign lvl_a = is_t ? ((sum > {1'b0, cap}) ? cap : sum[23:0]) : lvl_r;
  assign lvl_b = (full && (lvl_a > cap)) ? cap : lvl_a;
  assign cut   = full && (lvl_b >= TOKEN_ONE);

  assign lim  = (LW'(qlim_cfg_r) > LW'(Q)) ? LW'(Q) : LW'(qlim_cfg_r);
  assign qput = cut && (LW'(qc_r) < lim);
  assign disc = cut && !qput;

  assign pop_hit  = is_p && (qc_r != '0);
  assign pop_last = pop_hit && (roff_r == PW'(P - 1));

  assign qt_inc = (qt_r == QW'(Q - 1)) ? '0 : qt_r + 1'b1;
  assign qh_inc = (qh_r == QW'(Q - 1)) ? '0 : qh_r + 1'b1;

  assign c_front = stg_v_r[sf_r]   ? stg_tab_r[sf_r]   : CW'(sf_r);
  assign c_wr    = stg_v_r[wpos_r] ? stg_tab_r[wpos_r] : CW'(wpos_r);
  assign c_tail  = tail_sel_r ? tail_rd_r : tail_dflt_r;
  assign c_head  = head_sel_r ? head_rd_r : head_wr_r;

  assign wr_addr = AW'(c_wr) * AW'(P) + AW'(fill_r);
  assign rd_addr = AW'(c_head) * AW'(P) + AW'(roff_r);

  assign lvl_nxt  = cut ? (lvl_b - TOKEN_ONE) : lvl_b;
  assign scnt_nxt = cut ? (scnt_a - SCW'(P)) : scnt_a;
  assign qc_nxt   = qc_r + QCW'(qput) - QCW'(pop_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refill_r   <= RST_REFILL;
      cap_cfg_r  <= RST_CAP;
      qlim_cfg_r <= RST_QLIMIT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_REFILL:   refill_r   <= cfg_wdata;
        CFG_CAPACITY: cap_cfg_r  <= cfg_wdata[7:0];
        CFG_QLIMIT:   qlim_cfg_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r       <= {RST_CAP, 16'h0000};
      seq_r       <= '0;
      scnt_r      <= '0;
      sf_r        <= '0;
      wpos_r      <= '0;
      fill_r      <= '0;
      roff_r      <= '0;
      qh_r        <= '0;
      qt_r        <= '0;
      qc_r        <= '0;
      stg_v_r     <= '0;
      tail_sel_r  <= 1'b0;
      tail_dflt_r <= CW'(NS);
      head_sel_r  <= 1'b0;
      head_wr_r   <= CW'(NS);
    end else begin
      lvl_r  <= lvl_nxt;
      scnt_r <= scnt_nxt;
      qc_r   <= qc_nxt;
      if (stg_wr) begin
        if (fill_r == PW'(P - 1)) begin
          fill_r <= '0;
          wpos_r <= (wpos_r == NSW'(NS - 1)) ? '0 : wpos_r + 1'b1;
        end else begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cut) begin
        seq_r <= seq_r + 32'd1;
        sf_r  <= (sf_r == NSW'(NS - 1)) ? '0 : sf_r + 1'b1;
      end
      // a queued packet swaps chunks with the empty tail slot: no copy
      if (qput) begin
        stg_tab_r[sf_r] <= c_tail;
        stg_v_r[sf_r]   <= 1'b1;
        // every slot has been written once the tail has wrapped
        tail_sel_r  <= (Q > 1) && (tail_sel_r || (qt_r == QW'(Q - 1)));
        tail_dflt_r <= (Q > 1) ? CW'(NS) + CW'(qt_inc) : c_front;
        if (qc_r == '0) begin
          head_wr_r  <= c_front;
          head_sel_r <= 1'b0;
        end
        qt_r <= qt_inc;
      end
      if (pop_hit) begin
        if (pop_last) begin
          roff_r     <= '0;
          qh_r       <= qh_inc;
          head_sel_r <= 1'b1;
        end else begin
          roff_r <= roff_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_wr) begin
      mem[wr_addr] <= item.data_byte;
    end
    if (qput) begin
      seqm[qt_r]     <= seq_r;
      slot_mem[qt_r] <= c_front;
      tail_rd_r      <= slot_mem[qt_inc];
    end
    if (pop_last) begin
      head_rd_r <= slot_mem[qh_inc];
    end
    rd_byte_r <= mem[rd_addr];
    rd_seq_r  <= seqm[qh_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r <= 1'b0;
    end else begin
      s1v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= stg_wr || pop_hit;
    hit_r  <= pop_hit;
    last_r <= pop_last;
    drop_r <= is_b && !stg_wr;
    form_r <= cut;
    disc_r <= disc;
    qp_r   <= 8'(qc_nxt);
  end

  assign res_valid            = s1v_r;
  assign res.accepted         = acc_r;
  assign res.out_byte         = hit_r ? rd_byte_r : 8'h00;
  assign res.seq_number       = hit_r ? rd_seq_r : 32'h0;
  assign res.last_of_packet   = last_r;
  assign res.byte_dropped     = drop_r;
  assign res.packet_formed    = form_r;
  assign res.packet_discarded = disc_r;
  assign res.queued_packets   = qp_r;

endmodule

FILE: hw/rtl/rlp_queue.sv
// ----------------------------------------------------------------------------
// rlp_queue: result queue
// Short FIFO holding finished results until the receiver takes them.
// ----------------------------------------------------------------------------
module rlp_queue import rlp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        push_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  output logic [OQ_CW-1:0] count
);

  out_item_t        buf_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, rp_r;
  logic [OQ_CW-1:0] cnt_r;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = buf_r[rp_r];
  assign count     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + OQ_CW'(push) - OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/rate_limited_packetizer.sv
// ----------------------------------------------------------------------------
// rate_limited_packetizer: token bucket packetizer
// Stages stream bytes, cuts payloads under a token bucket, queues packets.
// ----------------------------------------------------------------------------
// Use:
//  - in_valid/in_stall/in_data carry one item per cycle while in_stall is low:
//    a stream byte, a tick or a pop. Every item gives exactly one result item.
//  - out_valid/out_stall/out_data return results in item order.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write refill, capacity and queue
//    limit; write only while idle. cfg_ready is always high.
// Timing: one item per cycle while in_stall is low; a result passes the
//  bookkeeping register, then the result queue, before it appears. The
//  bookkeeping register holds the registered read of the packet memory.
// Stage and packets share one pool of payload-sized chunks; queuing a packet
//  swaps chunk numbers between the stage map and the free tail slot, so no
//  bytes are copied.
// Reset: bucket full at 60 tokens, stage and queue empty, registers at their
//  defaults; no clearing pass.
// Stall: results collect in a four-entry queue; in_stall rises once it and
//  the in-flight result would fill it, so nothing is lost.
// ----------------------------------------------------------------------------
module rate_limited_packetizer import rlp_pkg::*; #(
  parameter int PAYLOAD_BYTES = 256,
  parameter int QUEUE_PACKETS = 128,
  parameter int STAGE_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic             take;
  logic             res_valid;
  out_item_t        res;
  logic [OQ_CW-1:0] q_cnt;

  // count results still owed, including the one in the bookkeeping register
  assign in_stall  = (32'(q_cnt) + 32'(res_valid)) >= OQ_DEPTH;
  assign take      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  rlp_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .QUEUE_PACKETS (QUEUE_PACKETS),
    .STAGE_BYTES   (STAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  rlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_cnt)
  );

endmodule
